@@ rtl/core/sfr_pkg.sv @@
package sfr_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned FrameBytes  = 4;
  localparam int unsigned QueueDepth  = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [FrameBytes-1:0][ByteW-1:0] frame_t;

  localparam logic [1:0] TagFirst  = 2'd1;
  localparam logic [1:0] TagSecond = 2'd2;

  localparam byte_t LowMask    = 8'h1F;
  localparam byte_t SecondMark = 8'hA0;
  localparam byte_t ThirdByte  = 8'h80;
  localparam byte_t TallyMax   = 8'hFF;
  localparam byte_t TallyLimit = 8'd1;

  localparam frame_t OffFrame0 = {8'hA0, 8'hC0, 8'h80, 8'h20};
  localparam frame_t OffFrame1 = {8'hC0, 8'hC0, 8'h80, 8'h00};

endpackage

@@ rtl/core/sfr_front.sv @@
module sfr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  sfr_pkg::byte_t       data_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output sfr_pkg::frame_t      q_frame
);
  import sfr_pkg::*;

  logic       toggle_bit;
  logic       active_mode;
  byte_t      error_tally;
  logic       awaiting_second;
  logic [3:0] pending_first;
  logic [3:0] pair_high_part;
  logic [4:0] pair_low_part;
  logic       pair_fresh;

  logic       accept;
  logic [1:0] tag;
  byte_t      tally_inc;
  byte_t      act_b0;
  byte_t      act_b1;
  byte_t      act_b3;
  logic       tally_over;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign tag        = data_byte[7:6];
  assign tally_inc  = (error_tally == TallyMax) ? error_tally : error_tally + 8'd1;
  assign tally_over = error_tally > TallyLimit;

  assign act_b0 = {2'b00, toggle_bit, 1'b0, pair_high_part};
  assign act_b1 = ({3'b000, pair_low_part} & LowMask) | SecondMark;
  assign act_b3 = 8'd0 - (act_b0 + act_b1 + ThirdByte);

  always_comb begin
    if (active_mode) begin
      q_frame = {act_b3, ThirdByte, act_b1, act_b0};
    end else if (toggle_bit) begin
      q_frame = OffFrame1;
    end else begin
      q_frame = OffFrame0;
    end
  end

  assign q_push = accept && func && !tally_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_bit      <= 1'b0;
      active_mode     <= 1'b0;
      error_tally     <= '0;
      awaiting_second <= 1'b0;
      pending_first   <= '0;
      pair_high_part  <= '0;
      pair_low_part   <= '0;
      pair_fresh      <= 1'b0;
    end else if (accept) begin
      if (func) begin
        if (tally_over) begin
          active_mode <= 1'b0;
          error_tally <= '0;
        end else begin
          toggle_bit <= !toggle_bit;
          if (active_mode) begin
            error_tally <= pair_fresh ? '0 : tally_inc;
            pair_fresh  <= 1'b0;
          end
        end
      end else if (data_byte != '0) begin
        if (!data_byte[5]) begin
          active_mode <= 1'b0;
        end else begin
          case (tag)
            TagFirst: begin
              if (awaiting_second) begin
                error_tally <= tally_inc;
              end
              pending_first   <= data_byte[3:0];
              awaiting_second <= 1'b1;
            end
            TagSecond: begin
              if (!awaiting_second) begin
                error_tally <= tally_inc;
              end else begin
                pair_high_part  <= pending_first;
                pair_low_part   <= data_byte[4:0];
                pair_fresh      <= 1'b1;
                active_mode     <= 1'b1;
                awaiting_second <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

endmodule

@@ rtl/core/sfr_queue.sv @@
module sfr_queue #(
  parameter int unsigned DEPTH = sfr_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sfr_pkg::frame_t push_frame,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output sfr_pkg::frame_t pop_frame
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frame_t            mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = count == CntW'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_frame = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/sfr_back.sv @@
module sfr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sfr_pkg::frame_t q_frame,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output sfr_pkg::byte_t  out_byte,
  output logic            frame_last
);
  import sfr_pkg::*;

  localparam int unsigned IdxW = $clog2(FrameBytes);

  frame_t          frame;
  logic [IdxW-1:0] idx;
  logic            busy;
  logic            advance;
  logic            last_byte;

  assign advance   = !out_valid || out_ready;
  assign last_byte = idx == IdxW'(FrameBytes - 1);
  assign q_pop     = q_valid && (!busy || (advance && last_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
        if (busy) begin
          out_byte   <= frame[idx];
          frame_last <= last_byte;
        end
      end
      if (q_pop) begin
        frame <= q_frame;
        idx   <= '0;
        busy  <= 1'b1;
      end else if (advance && busy) begin
        idx <= idx + 1'b1;
        if (last_byte) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/steer_frame_repeater_top.sv @@
// Steering frame repeater. A received control byte only updates the pairing state; a send
// tick queues a four-byte frame unless it is dropped on built-up errors. The output side
// sends one frame byte per cycle while out_ready stays high, and ticks are accepted back to
// back until the frame queue of QUEUE_DEPTH entries is full. Frame bytes appear in order,
// with frame_last on the fourth.
module steer_frame_repeater_top #(
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  input  sfr_pkg::byte_t data_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output sfr_pkg::byte_t out_byte,
  output logic           frame_last
);
  import sfr_pkg::*;

  logic   q_full;
  logic   q_push;
  frame_t q_in_frame;
  logic   q_pop;
  logic   q_valid;
  frame_t q_out_frame;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_frame   (q_in_frame)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_frame (q_in_frame),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_frame  (q_out_frame)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_frame    (q_out_frame),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .frame_last (frame_last)
  );

endmodule

@@ test/frame_checker.sv @@
module frame_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic           func,
  input  sfr_pkg::byte_t data_byte,
  input  logic           out_valid,
  input  logic           out_ready,
  input  sfr_pkg::byte_t out_byte,
  input  logic           frame_last,
  output int             mismatches,
  output int             bytes_due
);
  import sfr_pkg::*;

  typedef struct packed {
    byte_t value;
    logic  last;
  } frame_byte_t;

  frame_byte_t frame_bytes_due[$];

  logic       toggle;
  logic       active;
  byte_t      tally;
  logic       awaiting;
  byte_t      held_first;
  logic [3:0] pair_hi;
  logic [4:0] pair_lo;
  logic       fresh;

  task automatic bump_tally();
    if (tally != TallyMax) begin
      tally = tally + 8'd1;
    end
  endtask

  task automatic absorb_control_byte(input byte_t b);
    if (b == '0) begin
      return;
    end
    if (!b[5]) begin
      active = 1'b0;
    end else if (b[7:6] == TagFirst) begin
      if (awaiting) begin
        bump_tally();
      end
      held_first = b;
      awaiting   = 1'b1;
    end else if (b[7:6] == TagSecond) begin
      if (!awaiting) begin
        bump_tally();
      end else begin
        pair_hi  = held_first[3:0];
        pair_lo  = b[4:0];
        fresh    = 1'b1;
        active   = 1'b1;
        awaiting = 1'b0;
      end
    end
  endtask

  // A tick either is dropped on built-up errors or queues one four-byte frame.
  task automatic predict_frame();
    byte_t frame[4];
    int    sum;
    if (tally > TallyLimit) begin
      active = 1'b0;
      tally  = '0;
      return;
    end
    if (active) begin
      if (fresh) begin
        tally = '0;
      end else begin
        bump_tally();
      end
      frame[0] = {2'b00, toggle, 1'b0, pair_hi};
      frame[1] = {3'b000, pair_lo} | SecondMark;
      frame[2] = ThirdByte;
      sum      = (int'(frame[0]) + int'(frame[1]) + int'(frame[2])) % 512;
      frame[3] = byte_t'((512 - sum) % 256);
      fresh    = 1'b0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        frame[k] = toggle ? OffFrame1[k] : OffFrame0[k];
      end
    end
    for (int k = 0; k < 4; k++) begin
      frame_bytes_due.push_back({frame[k], k == 3});
    end
    toggle = ~toggle;
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      toggle     = 1'b0;
      active     = 1'b0;
      tally      = '0;
      awaiting   = 1'b0;
      held_first = '0;
      pair_hi    = '0;
      pair_lo    = '0;
      fresh      = 1'b0;
      mismatches = 0;
      frame_bytes_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected output transfer, out_byte %02h frame_last %0b",
                   $time, out_byte, frame_last);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_byte !== want.value) begin
            $display("%0t: out_byte expected %02h, actual %02h", $time, want.value, out_byte);
            mismatches++;
          end
          if (frame_last !== want.last) begin
            $display("%0t: frame_last expected %0b, actual %0b", $time, want.last,
                     frame_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (func) begin
          predict_frame();
        end else begin
          absorb_control_byte(data_byte);
        end
      end
    end
    bytes_due = frame_bytes_due.size();
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  import sfr_pkg::*;

  localparam logic       FuncByte   = 1'b0;
  localparam logic       FuncTick   = 1'b1;
  localparam logic [1:0] TagNone    = 2'd0;
  localparam logic [1:0] TagSpare   = 2'd3;
  localparam int         CycleLimit = 300000;
  localparam int         HoldCycles = 80;

  logic  clk;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  logic  func      = FuncByte;
  byte_t data_byte = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_byte;
  logic  frame_last;

  int    mismatches;
  int    bytes_due;
  int    send_idle = 31;
  int    recv_idle = 72;
  logic  hold_req  = 1'b0;
  logic  held      = 1'b0;
  int    cycles    = 0;

  steer_frame_repeater_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_last(frame_last)
  );

  frame_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_last(frame_last),
    .mismatches(mismatches),
    .bytes_due (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // The receiver stalls once for a long stretch so that the frame queue fills up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        held = 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input logic f, input byte_t d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_byte <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic byte_t first_byte();
    return {TagFirst, 1'b1, 5'($urandom_range(31))};
  endfunction

  function automatic byte_t second_byte();
    return {TagSecond, 1'b1, 5'($urandom_range(31))};
  endfunction

  task automatic run_random(input int target);
    int    taken;
    int    pick;
    int    ticks;
    taken = 0;
    while (taken < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_item(FuncByte, first_byte());
        taken++;
        if ($urandom_range(9) == 0) begin
          send_item(FuncByte, first_byte());
          taken++;
        end
        send_item(FuncByte, second_byte());
        ticks = $urandom_range(1, 3);
        for (int k = 0; k < ticks; k++) begin
          send_item(FuncTick, byte_t'($urandom_range(255)));
        end
        taken += 1 + ticks;
      end else if (pick < 75) begin
        send_item(FuncTick, byte_t'($urandom_range(255)));
        taken++;
      end else if (pick < 85) begin
        send_item(FuncByte, second_byte());
        taken++;
      end else begin
        send_item(FuncByte, byte_t'($urandom_range(255)));
        taken++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Off frames, a tick carrying data, and a zero byte.
    send_item(FuncTick, 8'h00);
    send_item(FuncTick, 8'hFF);
    send_item(FuncByte, 8'h00);
    // A fresh pair, two repeats, the tick that is dropped on errors, then an off frame.
    send_item(FuncByte, {TagFirst, 1'b1, 5'h0F});
    send_item(FuncByte, {TagSecond, 1'b1, 5'h1F});
    repeat (5) send_item(FuncTick, 8'h00);
    // The active bit clear ends active mode, then a second byte with none held.
    send_item(FuncByte, {TagFirst, 1'b1, 5'h03});
    send_item(FuncByte, {TagSecond, 1'b1, 5'h00});
    send_item(FuncByte, {TagFirst, 1'b0, 5'h1F});
    send_item(FuncByte, {TagSecond, 1'b1, 5'h11});
    send_item(FuncTick, 8'h00);
    send_item(FuncByte, {TagNone, 1'b1, 5'h00});
    send_item(FuncByte, {TagSpare, 1'b1, 5'h1F});
    // Two first bytes in a row replace the held one.
    send_item(FuncByte, {TagFirst, 1'b1, 5'h00});
    send_item(FuncByte, {TagFirst, 1'b1, 5'h05});
    send_item(FuncByte, {TagSecond, 1'b1, 5'h03});
    send_item(FuncTick, 8'h00);
    send_item(FuncTick, 8'h00);
    send_item(FuncByte, {TagFirst, 1'b1, 5'h01});
    send_item(FuncByte, {TagSecond, 1'b1, 5'h15});
    send_item(FuncTick, 8'h00);
    send_item(FuncByte, {TagSecond, 1'b0, 5'h1F});
    send_item(FuncTick, 8'h00);

    run_random(48);

    send_idle = 72;
    recv_idle = 31;
    run_random(48);

    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    repeat (8) send_item(FuncTick, byte_t'($urandom_range(255)));
    run_random(48);

    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && bytes_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
